// File: rtl/lpcd_pkg.sv
package lpcd_pkg;

    localparam int DATA_W      = 64;
    localparam int SLOT_W      = 3;
    localparam int DEF_ENTRIES = 8;

    // page key, compared as raw bits
    typedef struct packed {
        logic [DATA_W-1:0] seed;
        logic [DATA_W-1:0] col;
        logic [DATA_W-1:0] row;
    } key_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic              live;
        logic              hit_found;
        logic              free_found;
        logic              old_found;
        logic [DATA_W-1:0] old_stamp;
        key_t              old_key;
    } scan_t;

    // update command broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              set_key;
        key_t              key;
        logic [DATA_W-1:0] stamp;
    } wr_t;

endpackage

// File: rtl/lpcd_req_if.sv
interface lpcd_req_if;
    import lpcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [DATA_W-1:0] world_seed;
    logic signed [DATA_W-1:0] page_col;
    logic signed [DATA_W-1:0] page_row;

    modport source (output valid, output world_seed, output page_col, output page_row,
                    input ready);
    modport sink   (input valid, input world_seed, input page_col, input page_row,
                    output ready);
endinterface

// File: rtl/lpcd_rsp_if.sv
interface lpcd_rsp_if;
    import lpcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic        [SLOT_W-1:0] slot;
    logic                     evicted;
    logic        [DATA_W-1:0] victim_seed;
    logic signed [DATA_W-1:0] victim_col;
    logic signed [DATA_W-1:0] victim_row;

    modport source (output valid, output hit, output slot, output evicted,
                    output victim_seed, output victim_col, output victim_row,
                    input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input victim_seed, input victim_col, input victim_row,
                    output ready);
endinterface

// File: rtl/lpcd_cell.sv
module lpcd_cell
    import lpcd_pkg::*;
#(
    parameter int  ENTRIES = DEF_ENTRIES,
    parameter int  IDX     = 0,
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  key_t          key,
    input  scan_t         scan_in,
    input  logic [IW-1:0] hit_idx_in,
    input  logic [IW-1:0] free_idx_in,
    input  logic [IW-1:0] old_idx_in,
    output scan_t         scan_out,
    output logic [IW-1:0] hit_idx_out,
    output logic [IW-1:0] free_idx_out,
    output logic [IW-1:0] old_idx_out,
    input  wr_t           wr,
    input  logic [IW-1:0] wr_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic              valid_reg;
    key_t              key_reg;
    logic [DATA_W-1:0] stamp_reg;

    scan_t         scan_reg, scan_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;

    logic hit_take, free_take, old_take, sel;

    // this cell's contribution to the search
    always_comb
    begin
        hit_take  = valid_reg && (key_reg == key) && !scan_in.hit_found;
        free_take = !valid_reg && !scan_in.free_found;
        old_take  = valid_reg && (!scan_in.old_found || (stamp_reg < scan_in.old_stamp));

        scan_next            = scan_in;
        scan_next.hit_found  = scan_in.hit_found  || hit_take;
        scan_next.free_found = scan_in.free_found || free_take;
        scan_next.old_found  = scan_in.old_found  || old_take;
        hit_idx_next  = hit_take  ? MY_IDX : hit_idx_in;
        free_idx_next = free_take ? MY_IDX : free_idx_in;
        old_idx_next  = old_take  ? MY_IDX : old_idx_in;
        if (old_take)
        begin
            scan_next.old_stamp = stamp_reg;
            scan_next.old_key   = key_reg;
        end
    end

    // hand the search word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
    end

    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign old_idx_out  = old_idx_reg;

    // entry update
    assign sel = wr.en && (wr_idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && wr.set_key)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            stamp_reg <= wr.stamp;
            if (wr.set_key)
            begin
                key_reg <= wr.key;
            end
        end
    end

endmodule

// File: rtl/lru_page_cache_directory.sv
// Fully associative page directory with least-recently-used replacement. Each
// request word (world_seed, page_col, page_row) yields one response word: hit
// with the resident slot, or a new slot (lowest free slot first, else the entry
// with the oldest use stamp, whose key comes back as the victim). One request is
// in work at a time: a search word walks the row of ENTRIES cells, one cell per
// cycle, and the next request can be taken once the result has moved into the
// response register. A finished response waits in that output register without
// blocking the next request. All slots are empty after reset; no init sweep.
module lru_page_cache_directory
    import lpcd_pkg::*;
#(
    parameter int  ENTRIES = DEF_ENTRIES,
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic       clk,
    input  logic       rst_n,
    lpcd_req_if.sink   req,
    lpcd_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic              start_reg, start_next;
    logic [DATA_W-1:0] count_reg, count_next;
    key_t              key_reg;

    // pending result between search end and response register
    logic          res_hit_reg;
    logic          res_evict_reg;
    logic [IW-1:0] res_idx_reg;
    key_t          res_victim_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_hit_reg;
    logic [SLOT_W-1:0] rsp_slot_reg;
    logic              rsp_evicted_reg;
    key_t              rsp_victim_reg;

    scan_t         scan   [ENTRIES+1];
    logic [IW-1:0] hit_idx  [ENTRIES+1];
    logic [IW-1:0] free_idx [ENTRIES+1];
    logic [IW-1:0] old_idx  [ENTRIES+1];

    wr_t           wr;
    logic [IW-1:0] wr_idx;
    logic          accept, scan_end, rsp_load;
    key_t          victim;
    logic          evict;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign scan_end  = (state_reg == ST_SCAN) && scan[ENTRIES].live;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // search word entering the first cell
    assign scan[0]     = '{live: start_reg, default: '0};
    assign hit_idx[0]  = '0;
    assign free_idx[0] = '0;
    assign old_idx[0]  = '0;

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lpcd_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .key          (key_reg),
            .scan_in      (scan[i]),
            .hit_idx_in   (hit_idx[i]),
            .free_idx_in  (free_idx[i]),
            .old_idx_in   (old_idx[i]),
            .scan_out     (scan[i+1]),
            .hit_idx_out  (hit_idx[i+1]),
            .free_idx_out (free_idx[i+1]),
            .old_idx_out  (old_idx[i+1]),
            .wr           (wr),
            .wr_idx       (wr_idx)
        );
    end

    // decide at the end of the search and update the chosen entry
    always_comb
    begin
        evict       = !scan[ENTRIES].hit_found && !scan[ENTRIES].free_found;
        victim      = evict ? scan[ENTRIES].old_key : '0;
        wr.en       = scan_end;
        wr.set_key  = !scan[ENTRIES].hit_found;
        wr.key      = key_reg;
        wr.stamp    = count_reg;
        priority if (scan[ENTRIES].hit_found)
            wr_idx = hit_idx[ENTRIES];
        else if (scan[ENTRIES].free_found)
            wr_idx = free_idx[ENTRIES];
        else
            wr_idx = old_idx[ENTRIES];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        start_next     = accept;
        count_next     = accept ? count_reg + 1'b1 : count_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;
        if (rsp_load)
            rsp_valid_next = 1'b1;
        unique case (state_reg)
            ST_IDLE: if (accept)   state_next = ST_SCAN;
            ST_SCAN: if (scan_end) state_next = ST_DONE;
            ST_DONE: if (rsp_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // request key, pending result and response words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.seed <= req.world_seed;
            key_reg.col  <= req.page_col;
            key_reg.row  <= req.page_row;
        end
        if (scan_end)
        begin
            res_hit_reg    <= scan[ENTRIES].hit_found;
            res_evict_reg  <= evict;
            res_idx_reg    <= wr_idx;
            res_victim_reg <= victim;
        end
        if (rsp_load)
        begin
            rsp_hit_reg     <= res_hit_reg;
            rsp_slot_reg    <= SLOT_W'(res_idx_reg);
            rsp_evicted_reg <= res_evict_reg;
            rsp_victim_reg  <= res_victim_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.slot        = rsp_slot_reg;
    assign rsp.evicted     = rsp_evicted_reg;
    assign rsp.victim_seed = rsp_victim_reg.seed;
    assign rsp.victim_col  = rsp_victim_reg.col;
    assign rsp.victim_row  = rsp_victim_reg.row;

endmodule
